[design/heater_p_control_sqrt_pwm_defines.svh]
// Assertion macros for the heater proportional controller.
// Included by the RTL files that carry assertions; expects clk and rst_n in scope.
`ifndef HEATER_P_CONTROL_SQRT_PWM_DEFINES_SVH
`define HEATER_P_CONTROL_SQRT_PWM_DEFINES_SVH

`ifndef SYNTH
// clocked check, off while reset is asserted
`define HPCSP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// clocked check that also holds during reset
`define HPCSP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define HPCSP_ASSERT(lbl, prop, msg)
`define HPCSP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[design/hpcsp_pkg.sv]
// Shared types and constants for the heater proportional controller.
// No dependencies; used by the top level and its serial arithmetic units.
package hpcsp_pkg;

    localparam int TEMP_W     = 16;
    localparam int GAIN_W     = 15;
    localparam int STATUS_W   = 12;
    localparam int DUTY_W     = 8;
    localparam int PCT_W      = 7;
    localparam int CNT_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int PROD_W     = TEMP_W + GAIN_W;
    localparam int SQRT_IN_W  = 16;
    localparam int ROOT_W     = SQRT_IN_W / 2;

    // position of the stable-temperature bit in the status word
    localparam int STABLE_BIT = 8;

    localparam logic [STATUS_W-1:0] STATUS_KEEP_MASK = 12'h0F3F;
    localparam logic [STATUS_W-1:0] BAND_LOW_BIT     = 12'h0040;
    localparam logic [STATUS_W-1:0] BAND_HIGH_BIT    = 12'h0080;
    localparam logic [STATUS_W-1:0] ENABLE_BIT       = 12'h0008;
    localparam logic [DUTY_W-1:0]   DUTY_MAX         = 8'hFF;
    localparam logic [CNT_W-1:0]    CNT_STABLE       = 8'hFF;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MARGIN_LOW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MARGIN_HIGH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STABLE_TICKS = 3'd4;

    // status of a serial arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;     // one-cycle pulse, result valid in that cycle
    } unit_stat_t;

endpackage

[design/hpcsp_mul.sv]
// Bit-serial shift-add multiplier: |error| times gain, one gain bit per cycle.
// Depends on hpcsp_pkg.
module hpcsp_mul
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [hpcsp_pkg::TEMP_W-1:0]        mag,
    input  logic [hpcsp_pkg::GAIN_W-1:0]        gain,
    output hpcsp_pkg::unit_stat_t               stat,
    output logic [hpcsp_pkg::PROD_W-1:0]        product
);

    localparam int STEP_W = $clog2(hpcsp_pkg::GAIN_W);

    logic [hpcsp_pkg::TEMP_W-1:0] acc_reg;
    logic [hpcsp_pkg::GAIN_W-1:0] q_reg;
    logic [hpcsp_pkg::TEMP_W-1:0] mag_reg;
    logic [STEP_W-1:0]            step_reg;
    logic                         busy_reg;
    logic                         done_reg;
    logic [hpcsp_pkg::TEMP_W:0]   sum;

    // add the multiplicand when the current multiplier bit is set
    assign sum = {1'b0, acc_reg} + (q_reg[0] ? {1'b0, mag_reg} : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(hpcsp_pkg::GAIN_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            q_reg   <= gain;
            mag_reg <= mag;
        end
        else if (busy_reg)
        begin
            acc_reg <= sum[hpcsp_pkg::TEMP_W:1];
            q_reg   <= {sum[0], q_reg[hpcsp_pkg::GAIN_W-1:1]};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign product   = {acc_reg, q_reg};

endmodule

[design/hpcsp_sqrt.sv]
// Digit-serial floor square root, one root bit (two radicand bits) per cycle.
// Depends on hpcsp_pkg.
module hpcsp_sqrt
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [hpcsp_pkg::SQRT_IN_W-1:0]     radicand,
    output hpcsp_pkg::unit_stat_t               stat,
    output logic [hpcsp_pkg::ROOT_W-1:0]        root
);

    localparam int RN    = hpcsp_pkg::ROOT_W;
    localparam int XN    = hpcsp_pkg::SQRT_IN_W;
    localparam int REM_W = RN + 1;
    localparam int STEP_W = $clog2(RN);

    logic [XN-1:0]     x_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [RN-1:0]     root_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;
    logic [REM_W+1:0]  diff;
    logic              fits;

    assign rem_sh = {rem_reg, x_reg[XN-1 -: 2]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign fits   = rem_sh >= trial;
    assign diff   = rem_sh - trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(RN - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            x_reg <= {x_reg[XN-3:0], 2'b00};
            if (fits)
            begin
                rem_reg  <= diff[REM_W-1:0];
                root_reg <= {root_reg[RN-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh[REM_W-1:0];
                root_reg <= {root_reg[RN-2:0], 1'b0};
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign root      = root_reg;

endmodule

[design/heater_p_control_sqrt_pwm.sv]
// Top level of the heater proportional controller with square-root PWM duty.
// Depends on hpcsp_pkg, hpcsp_mul, hpcsp_sqrt and the assertion macro header.
//
//  channel  | signals                         | direction | contents
//  ---------+---------------------------------+-----------+---------------------------
//  s_       | s_tvalid s_tready s_tdata[31:0] | in        | control tick
//  m_       | m_tvalid m_tready m_tdata[31:0] | out       | duty, percent, status
//  cfg_     | cfg_valid cfg_ready cfg_index   | in        | register write
//           | cfg_data[15:0]                  |           |
//
// Steps: an enabled tick passes from its transfer through the band update, the
//   bit-serial multiplier (one gain bit a cycle), the digit-serial square root
//   (one root bit a cycle) and the percent conversion before its result is loaded.
// A tick with the enable bit clear is taken and gives no result.
// Reset: rst_n is asynchronous; only control and configuration registers are reset.
// Stalls: s_tready is high only between ticks; a pending result in the output
//   register does not block a new tick, only the loading of the next result.
// cfg_ready is always high; writes to indexes beyond the list are dropped.
`include "heater_p_control_sqrt_pwm_defines.svh"

module heater_p_control_sqrt_pwm
(
    input  logic        clk,
    input  logic        rst_n,
    // [15:0] measured_temp, [27:16] status_in, [31:28] zero
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    // [7:0] pwm_duty, [14:8] power_percent, [26:15] status_out, [31:27] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_BAND = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_SQRT = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    localparam int TW = hpcsp_pkg::TEMP_W;
    localparam int SW = hpcsp_pkg::STATUS_W;
    localparam int DW = hpcsp_pkg::DUTY_W;
    localparam int PW = hpcsp_pkg::PCT_W;
    localparam int CW = hpcsp_pkg::CNT_W;

    localparam logic [CW-1:0] CNT_FULL = hpcsp_pkg::CNT_STABLE;

    // configuration
    logic signed [TW-1:0]            setpoint_reg;
    logic [hpcsp_pkg::GAIN_W-1:0]    gain_reg;
    logic signed [TW-1:0]            margin_low_reg;
    logic signed [TW-1:0]            margin_high_reg;
    logic [CW-1:0]                   stable_ticks_reg;

    // control and item state
    logic [2:0]                      state_reg;
    logic [2:0]                      state_next;
    logic [CW-1:0]                   count_reg;
    logic signed [TW-1:0]            err_reg;
    logic [SW-1:0]                   st_reg;
    logic [DW-1:0]                   duty_reg;

    // output register
    logic                            m_valid_reg;
    logic [DW-1:0]                   out_duty_reg;
    logic [PW-1:0]                   out_pct_reg;
    logic [SW-1:0]                   out_st_reg;

    logic                            in_xfer;
    logic                            cfg_xfer;
    logic                            out_load;
    logic signed [TW-1:0]            meas;
    logic [SW-1:0]                   st_in;

    // band logic
    logic                            too_low;
    logic                            too_high;
    logic                            in_band;
    logic [CW-1:0]                   count_step;
    logic                            stable;
    logic                            band_stable;
    logic [SW-1:0]                   st_new;
    logic [TW-1:0]                   mag;

    // arithmetic units
    hpcsp_pkg::unit_stat_t           mul_stat;
    hpcsp_pkg::unit_stat_t           sqrt_stat;
    logic [hpcsp_pkg::PROD_W-1:0]    product;
    logic [hpcsp_pkg::SQRT_IN_W-1:0] radicand;
    logic [hpcsp_pkg::ROOT_W-1:0]    root;
    logic                            mul_start;
    logic                            sqrt_start;

    // percent: duty * 100 / 255 via (n + n/256 + 1) / 256, exact for n < 65535
    logic [14:0]                     pct_n;
    logic [15:0]                     pct_sum;

    assign meas     = s_tdata[TW-1:0];
    assign st_in    = s_tdata[TW +: SW];
    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign cfg_xfer = cfg_valid && cfg_ready;
    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_tready);

    // ---- configuration registers ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setpoint_reg     <= '0;
            gain_reg         <= 15'd9000;
            margin_low_reg   <= -16'sd2;
            margin_high_reg  <= 16'sd2;
            stable_ticks_reg <= 8'd50;
        end
        else if (cfg_xfer)
        begin
            case (cfg_index)
                hpcsp_pkg::REG_SETPOINT:     setpoint_reg     <= cfg_data;
                hpcsp_pkg::REG_GAIN_PROP:    gain_reg         <= cfg_data[14:0];
                hpcsp_pkg::REG_MARGIN_LOW:   margin_low_reg   <= cfg_data;
                hpcsp_pkg::REG_MARGIN_HIGH:  margin_high_reg  <= cfg_data;
                hpcsp_pkg::REG_STABLE_TICKS: stable_ticks_reg <= cfg_data[CW-1:0];
                default: ;
            endcase
        end
    end

    // ---- band code and in-band counter ----
    // low and in-band tests exclude each other, as do high and in-band
    assign too_low  = err_reg < margin_low_reg;
    assign too_high = err_reg > margin_high_reg;
    assign in_band  = (err_reg > margin_low_reg) && (err_reg < margin_high_reg);

    always_comb
    begin
        if (in_band)
            count_step = count_reg + 1'b1;
        else if (too_low || too_high)
            count_step = '0;
        else
            count_step = count_reg;
    end

    assign stable = (count_step == stable_ticks_reg);
    assign band_stable = (state_reg == ST_BAND) && stable;
    assign st_new = (st_reg & hpcsp_pkg::STATUS_KEEP_MASK)
                  | ((too_low  || in_band) ? hpcsp_pkg::BAND_LOW_BIT  : '0)
                  | ((too_high || in_band) ? hpcsp_pkg::BAND_HIGH_BIT : '0)
                  | (stable ? (SW'(1) << hpcsp_pkg::STABLE_BIT) : '0);

    // only a negative error gives positive drive; otherwise the product is zero
    assign mag = err_reg[TW-1] ? (~err_reg + TW'(1)) : '0;

    // ---- sequencer ----
    assign mul_start  = (state_reg == ST_BAND);
    assign sqrt_start = (state_reg == ST_MUL) && mul_stat.done;
    // root saturates at 255 once the drive reaches 2^16
    assign radicand = (|product[hpcsp_pkg::PROD_W-1:hpcsp_pkg::SQRT_IN_W])
                    ? '1 : product[hpcsp_pkg::SQRT_IN_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_xfer && ((st_in & hpcsp_pkg::ENABLE_BIT) != '0))
                    state_next = ST_BAND;
            ST_BAND:
                state_next = ST_MUL;
            ST_MUL:
                if (mul_stat.done)
                    state_next = ST_SQRT;
            ST_SQRT:
                if (sqrt_stat.done)
                    state_next = ST_OUT;
            ST_OUT:
                if (out_load)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_BAND)
                count_reg <= stable ? CNT_FULL : count_step;
            if (out_load)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    // ---- item payload ----
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            err_reg <= meas - setpoint_reg;
            st_reg  <= st_in;
        end
        else if (state_reg == ST_BAND)
            st_reg <= st_new;
        if (sqrt_stat.done)
            duty_reg <= root;
        if (out_load)
        begin
            out_duty_reg <= duty_reg;
            out_pct_reg  <= pct_sum[14:8];
            out_st_reg   <= st_reg;
        end
    end

    assign pct_n   = {1'b0, duty_reg, 6'b0} + {2'b0, duty_reg, 5'b0} + {5'b0, duty_reg, 2'b0};
    assign pct_sum = {1'b0, pct_n} + {9'b0, pct_n[14:8]} + 16'd1;

    hpcsp_mul u_mul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mag     (mag),
        .gain    (gain_reg),
        .stat    (mul_stat),
        .product (product)
    );

    hpcsp_sqrt u_sqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (radicand),
        .stat     (sqrt_stat),
        .root     (root)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, out_st_reg, out_pct_reg, out_duty_reg};

    // ---- checks ----
    // status_in may already carry the stable bit, so the counter is checked
    // against the band update itself
    `HPCSP_ASSERT(a_mul_in_state, mul_stat.busy |-> (state_reg == ST_MUL), "mul off phase")
    `HPCSP_ASSERT(a_sqrt_in_state, sqrt_stat.busy |-> (state_reg == ST_SQRT), "root off phase")
    `HPCSP_ASSERT(a_stable_count, band_stable |=> (count_reg == CNT_FULL), "count not full")
    `HPCSP_ASSERT(a_pct_range, m_valid_reg |-> (out_pct_reg <= 7'd100), "percent above full scale")

endmodule
